// ===== rtl/iirdf1_pkg.sv =====
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared constants, coefficient table and helper functions for the
// fifth-order direct-form-I IIR filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int FEEDFORWARD_TAPS = 6;
   localparam int FEEDBACK_TAPS    = 6;

   // history depth and slot index width
   localparam int HIST_DEPTH = FEEDFORWARD_TAPS - 1;
   localparam int SLOT_W     = $clog2(HIST_DEPTH);

   // number formats
   localparam int COEF_W  = 32;             // Q4.28 coefficients
   localparam int Y_W     = 48;             // Q24.24 past outputs
   localparam int FRAC_W  = 24;             // fraction bits of a past output
   localparam int MUL_B_W = FRAC_W + 1;     // second multiplier operand
   localparam int PROD_W  = COEF_W + MUL_B_W;
   localparam int ACC_W   = 82;             // Q52 accumulator
   localparam int RND_SHIFT = 4;            // Q28 to Q24

   // sequencer steps: b0..b5, then a1..a5 on the high and low half of y
   localparam int NUM_STEPS = FEEDFORWARD_TAPS + 2 * (FEEDBACK_TAPS - 1);
   localparam int STEP_W    = $clog2(NUM_STEPS);
   localparam logic [STEP_W-1:0] FIRST_STEP   = '0;
   localparam logic [STEP_W-1:0] LAST_FF_STEP = STEP_W'(FEEDFORWARD_TAPS - 1);
   localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(NUM_STEPS - 1);
   localparam logic [STEP_W-2:0] FB_BASE      = (STEP_W-1)'(FEEDFORWARD_TAPS / 2 - 1);

   localparam logic signed [COEF_W-1:0] COEF_B [FEEDFORWARD_TAPS] = '{
      32'sd107374, 32'sd483184, 32'sd993211, 32'sd993211, 32'sd483184, 32'sd107374
   };

   // index 0 is the leading 1.0 and never enters the sum
   localparam logic signed [COEF_W-1:0] COEF_A [FEEDBACK_TAPS] = '{
      32'sd268435456, -32'sd933860108, 32'sd1344807947, -32'sd993076969,
      32'sd374252713, -32'sd57391500
   };

   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic                       last;
      logic                       scaled;   // weight 2^24 in Q52
      logic                       negate;
      logic signed [COEF_W-1:0]   coef;
      logic signed [MUL_B_W-1:0]  operand;
   } mac_op_type;

   function automatic logic signed [COEF_W-1:0] coef_of(input logic [STEP_W-1:0] step);
      logic [STEP_W-2:0] fb_idx;
      fb_idx = step[STEP_W-1:1] - FB_BASE;
      if (step <= LAST_FF_STEP) begin
         return COEF_B[step[SLOT_W-1:0]];
      end
      return COEF_A[fb_idx[SLOT_W-1:0]];
   endfunction

   function automatic logic [SLOT_W-1:0] dec_slot(input logic [SLOT_W-1:0] slot);
      if (slot == '0) begin
         return SLOT_W'(HIST_DEPTH - 1);
      end
      return slot - 1'b1;
   endfunction

endpackage

// ===== rtl/iirdf1_hist.sv =====
// ----------------------------------------------------------------------------
// iirdf1_hist
// Circular history of past inputs and past outputs, one synchronous memory
// each, sharing one read address and one write pointer. Slots never written
// since reset are flagged by rd_ok low.
// ----------------------------------------------------------------------------
module iirdf1_hist
   import iirdf1_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic        [SLOT_W-1:0]       rd_addr,
   output logic signed [SAMPLE_WIDTH-1:0] rd_x,
   output logic signed [Y_W-1:0]          rd_y,
   output logic                           rd_ok,
   input  logic                           wr_en,
   input  logic signed [SAMPLE_WIDTH-1:0] wr_x,
   input  logic signed [Y_W-1:0]          wr_y,
   output logic        [SLOT_W-1:0]       wr_slot
);

   logic signed [SAMPLE_WIDTH-1:0] xmem [HIST_DEPTH];
   logic signed [Y_W-1:0]          ymem [HIST_DEPTH];

   logic [HIST_DEPTH-1:0]    valid_ff;
   logic [SLOT_W-1:0]        wp_ff;
   logic signed [SAMPLE_WIDTH-1:0] rd_x_ff;
   logic signed [Y_W-1:0]    rd_y_ff;
   logic                     rd_ok_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         xmem[wp_ff] <= wr_x;
         ymem[wp_ff] <= wr_y;
      end
      rd_x_ff <= xmem[rd_addr];
      rd_y_ff <= ymem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wp_ff    <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wp_ff] <= 1'b1;
            wp_ff <= (wp_ff == SLOT_W'(HIST_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
      end
   end

   assign rd_x    = rd_x_ff;
   assign rd_y    = rd_y_ff;
   assign rd_ok   = rd_ok_ff;
   assign wr_slot = wp_ff;

endmodule

// ===== rtl/iirdf1_mac.sv =====
// ----------------------------------------------------------------------------
// iirdf1_mac
// Shared multiply-accumulate unit: registered 32x25 signed product, then a
// Q52 accumulate with optional 2^24 weight and sign.
// ----------------------------------------------------------------------------
module iirdf1_mac
   import iirdf1_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mac_op_type              op,
   output logic signed [ACC_W-1:0] acc,
   output logic                    done
);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     valid_ff;
   logic                     first_ff;
   logic                     last_ff;
   logic                     scaled_ff;
   logic                     negate_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     done_ff;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  sterm;

   always_ff @(posedge clock) begin
      prod_ff   <= op.coef * op.operand;
      first_ff  <= op.first;
      last_ff   <= op.last;
      scaled_ff <= op.scaled;
      negate_ff <= op.negate;
   end

   always_comb begin
      term   = scaled_ff ? (ACC_W'(prod_ff) <<< FRAC_W) : ACC_W'(prod_ff);
      sterm  = negate_ff ? -term : term;
      acc_in = (first_ff ? '0 : acc_ff) + sterm;
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         valid_ff <= op.valid;
         done_ff  <= valid_ff && last_ff;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

// ===== rtl/iir_direct_form_one_filter.sv =====
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Fifth-order direct-form-I IIR low-pass filter with fixed coefficients.
// ----------------------------------------------------------------------------
// Each input word is one signed sample; each yields one filtered sample,
// rounded and saturated to SAMPLE_WIDTH bits. Past inputs and past outputs
// (Q24.24) live in two small memories; one shared 32x25 multiplier runs
// sixteen products per sample (six feedforward, five feedback taps split
// into high and low halves of the stored output). Each sample runs the
// sixteen passes through the multiplier plus the read, product,
// accumulate and rounding stages, and the next sample starts only once
// the result has been emitted. One sample waits in an input register
// and one result in an output register, so both sides may stall freely.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter
   import iirdf1_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] req_tdata,  // [0] sample_in
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] rsp_tdata   // [0] sample_out
);

   localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int ACCQ_W = ACC_W - FRAC_W;          // Q28 sum width
   localparam int YSH_W  = ACCQ_W + 1 - RND_SHIFT;  // Q24 before clamp
   localparam int YO_W   = Y_W + 1 - FRAC_W;        // integer before clamp

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W - 1){1'b1}}};
   localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W - 1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

   logic [1:0]               state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [SLOT_W-1:0]        addr_ff, addr_in;
   logic [STEP_W-1:0]        step_d_ff;
   logic                     issue_ff;
   logic                     in_full_ff, in_full_in;
   logic [SAMPLE_WIDTH-1:0]  in_data_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [Y_W-1:0]    ynew_ff, ynew_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   logic                     out_free;
   logic                     take;
   logic                     emit;
   logic                     req_accept;

   logic [SLOT_W-1:0]        wr_slot;
   logic signed [SAMPLE_WIDTH-1:0] rd_x;
   logic signed [Y_W-1:0]    rd_y;
   logic                     rd_ok;

   mac_op_type               op;
   logic signed [ACC_W-1:0]  acc;
   logic                     mac_done;

   logic signed [ACCQ_W:0]   rnd;
   logic signed [YSH_W-1:0]  ysh;
   logic signed [Y_W:0]      yo_sum;
   logic signed [YO_W-1:0]   yo;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = (state_ff == ST_EMIT) && out_free;
   assign take       = in_full_ff && ((state_ff == ST_IDLE) || emit);
   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !in_full_ff;
   assign in_full_in = (in_full_ff && !take) || req_accept;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_full_ff) begin
               state_in = ST_RUN;
               step_in  = FIRST_STEP;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            // walk back from the newest slot, once for inputs, once for outputs
            if (step_ff == FIRST_STEP || step_ff == LAST_FF_STEP) begin
               addr_in = dec_slot(wr_slot);
            end else if (step_ff < LAST_FF_STEP || step_ff[0]) begin
               addr_in = dec_slot(addr_ff);
            end
            if (step_ff == LAST_STEP) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = in_full_ff ? ST_RUN : ST_IDLE;
               step_in  = FIRST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // operand select, in the cycle after the memory address is presented
   always_comb begin
      op.valid  = issue_ff;
      op.first  = (step_d_ff == FIRST_STEP);
      op.last   = (step_d_ff == LAST_STEP);
      op.negate = (step_d_ff > LAST_FF_STEP);
      op.scaled = (step_d_ff <= LAST_FF_STEP) || !step_d_ff[0];
      op.coef   = coef_of(step_d_ff);
      if (step_d_ff == FIRST_STEP) begin
         op.operand = MUL_B_W'(x_ff);
      end else if (!rd_ok) begin
         op.operand = '0;
      end else if (step_d_ff <= LAST_FF_STEP) begin
         op.operand = MUL_B_W'(rd_x);
      end else if (!step_d_ff[0]) begin
         op.operand = MUL_B_W'($signed(rd_y[Y_W-1:FRAC_W]));
      end else begin
         op.operand = {1'b0, rd_y[FRAC_W-1:0]};
      end
   end

   // floor to Q28, round half up to Q24, clamp to 48 bits
   always_comb begin
      rnd = {acc[ACC_W-1], acc[ACC_W-1:FRAC_W]} + (ACCQ_W + 1)'(1 << (RND_SHIFT - 1));
      ysh = rnd[ACCQ_W:RND_SHIFT];
      if (&ysh[YSH_W-1:Y_W-1] || ~|ysh[YSH_W-1:Y_W-1]) begin
         ynew_in = ysh[Y_W-1:0];
      end else begin
         ynew_in = ysh[YSH_W-1] ? Y_MIN : Y_MAX;
      end
   end

   // round half up to an integer, clamp to the sample width
   always_comb begin
      yo_sum = {ynew_ff[Y_W-1], ynew_ff} + (Y_W + 1)'(1 << (FRAC_W - 1));
      yo     = yo_sum[Y_W:FRAC_W];
      if (&yo[YO_W-1:SAMPLE_WIDTH-1] || ~|yo[YO_W-1:SAMPLE_WIDTH-1]) begin
         rsp_data_in = yo[SAMPLE_WIDTH-1:0];
      end else begin
         rsp_data_in = yo[YO_W-1] ? S_MIN : S_MAX;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= FIRST_STEP;
         issue_ff     <= 1'b0;
         in_full_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         issue_ff     <= (state_ff == ST_RUN);
         in_full_ff   <= in_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      step_d_ff <= step_ff;
      if (req_accept) begin
         in_data_ff <= req_tdata[SAMPLE_WIDTH-1:0];
      end
      if (take) begin
         x_ff <= in_data_ff;
      end
      if (mac_done) begin
         ynew_ff <= ynew_in;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   iirdf1_hist #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (addr_ff),
      .rd_x    (rd_x),
      .rd_y    (rd_y),
      .rd_ok   (rd_ok),
      .wr_en   (emit),
      .wr_x    (x_ff),
      .wr_y    (ynew_ff),
      .wr_slot (wr_slot)
   );

   iirdf1_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .acc   (acc),
      .done  (mac_done)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);

`ifndef SYNTHESIS
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_DRAIN)
      else $error("accumulator finished outside drain");

   a_last_step_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_ff == LAST_STEP) |=> state_ff == ST_DRAIN)
      else $error("sequencer did not drain after last step");

   a_write_shows_result: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_tvalid)
      else $error("history written without a result word");

   a_no_issue_outside_run: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> $past(state_ff) == ST_RUN)
      else $error("operand issued outside run");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - fifth-order direct-form-I IIR filter testbench
// Streams signed samples into the filter and checks every filtered word
// against a bit-exact fixed-point model of the recursion held here, with
// random pauses on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_W = 16;
   localparam int NUM_RANDOM = 1800;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES = 400;

   // Q4.28 coefficients; a[0] is the leading 1.0 and is never summed
   localparam longint B_Q28 [0:5] = '{107374, 483184, 993211, 993211, 483184, 107374};
   localparam longint A_Q28 [0:5] = '{268435456, -933860108, 1344807947,
                                      -993076969, 374252713, -57391500};
   localparam longint Y_MAX = longint'(48'h7FFF_FFFF_FFFF);
   localparam longint Y_MIN = -Y_MAX - 1;
   localparam longint S_MAX = 32767;
   localparam longint S_MIN = -32768;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata = '0;   // [15:0] sample_in
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;        // [15:0] sample_out
   logic                hold_rsp = 1'b0;

   logic signed [SAMPLE_W-1:0] x_hist [0:4];
   logic signed [47:0]         y_hist_q24 [0:4];

   logic [SAMPLE_W-1:0] samples_to_send [$];
   logic [SAMPLE_W-1:0] filtered_due [$];

   logic [SAMPLE_W-1:0] y_next;
   logic [SAMPLE_W-1:0] y_want;
   int send_wait = 0;
   int send_calm = 0;
   int rsp_wait = 0;
   int rsp_calm = 0;
   int results_seen = 0;
   int mismatches = 0;

   iir_direct_form_one_filter #(
      .SAMPLE_WIDTH(SAMPLE_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #60ms;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // mostly short pauses, a few long ones
   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   // one step of the recursion: feedforward in Q28, feedback split into
   // integer and fraction halves of the Q24.24 history, floored to Q28
   task automatic predict_filtered(input logic signed [SAMPLE_W-1:0] x,
                                   output logic [SAMPLE_W-1:0] y);
      longint ff;
      longint fb_hi;
      longint fb_lo;
      longint acc;
      longint y_q24;
      longint y_int;
      longint y_old;
      ff = B_Q28[0] * longint'(x);
      fb_hi = 0;
      fb_lo = 0;
      for (int i = 1; i < 6; i++) begin
         ff += B_Q28[i] * longint'(x_hist[i-1]);
         y_old = longint'(y_hist_q24[i-1]);
         fb_hi += A_Q28[i] * (y_old >>> 24);
         fb_lo += A_Q28[i] * (y_old & longint'(24'hFF_FFFF));
      end
      acc = ff - fb_hi + ((-fb_lo) >>> 24);
      y_q24 = (acc + 8) >>> 4;
      if (y_q24 > Y_MAX) y_q24 = Y_MAX;
      if (y_q24 < Y_MIN) y_q24 = Y_MIN;
      y_int = (y_q24 + (longint'(1) << 23)) >>> 24;
      if (y_int > S_MAX) y_int = S_MAX;
      if (y_int < S_MIN) y_int = S_MIN;
      for (int i = 4; i > 0; i--) begin
         x_hist[i] = x_hist[i-1];
         y_hist_q24[i] = y_hist_q24[i-1];
      end
      x_hist[0] = x;
      y_hist_q24[0] = y_q24[47:0];
      y = y_int[SAMPLE_W-1:0];
   endtask

   // driver: hold the word until taken, then pause or advance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predict_filtered(req_tdata, y_next);
            filtered_due.push_back(y_next);
         end
         if (send_wait != 0) begin
            send_wait--;
            req_tvalid <= 1'b0;
         end else if (samples_to_send.size() != 0) begin
            req_tdata <= samples_to_send.pop_front();
            req_tvalid <= 1'b1;
            if (send_calm != 0) begin
               send_calm--;
            end else begin
               if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 150);
               send_wait = pick_pause();
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: check each filtered word, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (filtered_due.size() == 0) begin
               report_mismatch($sformatf("unexpected sample_out %0d", $signed(rsp_tdata)));
            end else begin
               y_want = filtered_due.pop_front();
               if (rsp_tdata !== y_want)
                  report_mismatch($sformatf("sample_out got %0d want %0d (word %0d)",
                                            $signed(rsp_tdata), $signed(y_want),
                                            results_seen));
            end
            if (rsp_calm != 0) begin
               rsp_calm--;
            end else begin
               if ($urandom_range(0, 49) == 0) rsp_calm = $urandom_range(30, 150);
               rsp_wait = pick_pause();
            end
         end
         rsp_tready <= !hold_rsp && rsp_wait == 0;
         if (rsp_wait != 0) rsp_wait--;
      end
   end

   // back-pressure: stop draining once so the filter fills and stalls its input
   initial begin
      wait (results_seen >= 300);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      int kind;
      int seg_len;
      int half;
      int level;
      int slope;
      logic [SAMPLE_W-1:0] word;

      for (int i = 0; i < 5; i++) begin
         x_hist[i] = '0;
         y_hist_q24[i] = '0;
      end

      // directed: extremes, single-bit patterns, impulse, full-scale steps
      samples_to_send.push_back(16'h0000);
      samples_to_send.push_back(16'h7FFF);
      samples_to_send.push_back(16'h8000);
      samples_to_send.push_back(16'h0001);
      samples_to_send.push_back(16'hFFFF);
      samples_to_send.push_back(16'h5555);
      samples_to_send.push_back(16'hAAAA);
      samples_to_send.push_back(16'h7FFF);
      repeat (4) samples_to_send.push_back(16'h0000);
      repeat (6) samples_to_send.push_back(16'h8000);
      repeat (6) samples_to_send.push_back(16'h7FFF);

      // random segments: noise, held levels long enough to saturate,
      // square waves, small values and ramps
      while (samples_to_send.size() < NUM_RANDOM + 24) begin
         kind = $urandom_range(0, 5);
         seg_len = $urandom_range(5, 80);
         level = $urandom_range(0, 65535) - 32768;
         half = $urandom_range(2, 40);
         slope = $urandom_range(0, 2047) - 1024;
         if (kind == 1) seg_len = $urandom_range(60, 200);
         for (int n = 0; n < seg_len; n++) begin
            case (kind)
               0: word = SAMPLE_W'($urandom);
               1: word = level[31] ? 16'h8000 : 16'h7FFF;
               2: word = level[SAMPLE_W-1:0];
               3: word = ((n / half) % 2 == 0) ? 16'h7FFF : 16'h8000;
               4: word = SAMPLE_W'($urandom_range(0, 15) - 8);
               default: begin
                  level += slope;
                  if (level > 32767) level = 32767;
                  if (level < -32768) level = -32768;
                  word = level[SAMPLE_W-1:0];
               end
            endcase
            samples_to_send.push_back(word);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (samples_to_send.size() != 0 || req_tvalid) @(posedge clock);
      while (filtered_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
